### hw/rtl/k_group_stream_reverser_defines.svh
// assertion macros for the k-group stream reverser checker
`ifndef K_GROUP_STREAM_REVERSER_DEFINES_SVH
`define K_GROUP_STREAM_REVERSER_DEFINES_SVH

// clocked assertion, off while reset is low
`define KGSR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("kgsr check failed");

// clocked assertion, also checked while reset is low
`define KGSR_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("kgsr check failed");

`endif

### hw/rtl/kgsr_pkg.sv
// shared types and constants for the k-group stream reverser
`default_nettype none

package kgsr_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CFG_W  = 5;

  typedef logic signed [DATA_W-1:0] value_t;
  typedef logic [CFG_W-1:0] cfg_t;

  typedef struct packed {
    logic shift_up;
    logic shift_down;
  } cell_ctrl_t;

endpackage

`default_nettype wire

### hw/rtl/k_group_stream_reverser.sv
// Reverses a stream of signed 32-bit items in groups of cfg_data_i items (0 acts as 1,
// values above MAX_GROUP act as MAX_GROUP). Items enter a row of MAX_GROUP cells, one per
// cycle; when a group fills, or tlast arrives first, s_axis_tready_o drops and the group
// leaves one item per cycle, unless m_axis_tready_i stalls it, through the output
// register: a full group newest first, a short group at the end of the list in arrival
// order. The single shift chain holds one group at a time. tlast out marks the final
// item of the list. Write the group size only while the block is idle.
`default_nettype none

module k_group_stream_reverser #(
  parameter int unsigned MAX_GROUP = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_valid_i,
  output      logic             cfg_ready_o,
  input  wire kgsr_pkg::cfg_t   cfg_data_i,     // group_size
  input  wire logic             s_axis_tvalid_i,
  output      logic             s_axis_tready_o,
  input  wire kgsr_pkg::value_t s_axis_tdata_i, // value
  input  wire logic             s_axis_tlast_i,
  output      logic             m_axis_tvalid_o,
  input  wire logic             m_axis_tready_i,
  output      kgsr_pkg::value_t m_axis_tdata_o, // value_out
  output      logic             m_axis_tlast_o
);
  import kgsr_pkg::*;

  localparam int unsigned CW   = $clog2(MAX_GROUP + 1);
  localparam int unsigned IDXW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

  cfg_t           size_q;
  logic [CW-1:0]  fill_q, remain_q, len_q;
  logic [CW-1:0]  k_eff, n_next;
  logic           rev_q, end_q;
  logic           out_valid_q, out_last_q;
  value_t         out_data_q;
  logic           s_accept, emit, group_done;
  logic [IDXW-1:0] tap_idx;
  cell_ctrl_t     ctrl;
  value_t         cell_val [MAX_GROUP];

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (remain_q == '0);
  assign s_accept        = s_axis_tvalid_i & s_axis_tready_o;
  assign emit            = (remain_q != '0) & (~out_valid_q | m_axis_tready_i);

  always_comb begin
    if (size_q == '0) begin
      k_eff = CW'(1);
    end else if (int'(size_q) > int'(MAX_GROUP)) begin
      k_eff = CW'(MAX_GROUP);
    end else begin
      k_eff = CW'(size_q);
    end
  end

  assign n_next     = fill_q + CW'(1);
  assign group_done = (n_next >= k_eff) | s_axis_tlast_i;
  assign tap_idx    = IDXW'(len_q - CW'(1));

  assign ctrl.shift_up   = s_accept | (emit & ~rev_q);
  assign ctrl.shift_down = emit & rev_q;

  for (genvar i = 0; i < MAX_GROUP; i++) begin : g_cell
    value_t lo, hi;
    if (i == 0) begin : g_first
      assign lo = s_axis_tdata_i;
    end else begin : g_mid
      assign lo = cell_val[i-1];
    end
    if (i == MAX_GROUP - 1) begin : g_last
      assign hi = cell_val[i];
    end else begin : g_inner
      assign hi = cell_val[i+1];
    end
    kgsr_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .from_lo_i (lo),
      .from_hi_i (hi),
      .value_o   (cell_val[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q      <= cfg_t'(1);
      fill_q      <= '0;
      remain_q    <= '0;
      len_q       <= '0;
      rev_q       <= 1'b0;
      end_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        size_q <= cfg_data_i;
      end
      if (s_accept) begin
        if (group_done) begin
          fill_q   <= '0;
          remain_q <= n_next;
          len_q    <= n_next;
          rev_q    <= (n_next >= k_eff);
          end_q    <= s_axis_tlast_i;
        end else begin
          fill_q <= n_next;
        end
      end else if (emit) begin
        remain_q <= remain_q - CW'(1);
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= rev_q ? cell_val[0] : cell_val[tap_idx];
      out_last_q <= end_q & (remain_q == CW'(1));
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

`default_nettype wire

### hw/rtl/kgsr_cell.sv
// one storage cell of the group chain, shifts toward either neighbor
`default_nettype none

module kgsr_cell (
  input  wire logic                clk_i,
  input  wire kgsr_pkg::cell_ctrl_t ctrl_i,
  input  wire kgsr_pkg::value_t    from_lo_i,
  input  wire kgsr_pkg::value_t    from_hi_i,
  output      kgsr_pkg::value_t    value_o
);
  import kgsr_pkg::*;

  value_t value_q, value_d;

  always_comb begin
    value_d = value_q;
    if (ctrl_i.shift_up) begin
      value_d = from_lo_i;
    end else if (ctrl_i.shift_down) begin
      value_d = from_hi_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

`default_nettype wire

### hw/rtl/kgsr_checker.sv
// port-level checks for the k-group stream reverser, bound to the top level
`default_nettype none
`include "k_group_stream_reverser_defines.svh"

module kgsr_checker (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             s_axis_tvalid_i,
  input wire logic             s_axis_tready_o,
  input wire logic             s_axis_tlast_i,
  input wire logic             m_axis_tvalid_o,
  input wire logic             m_axis_tready_i,
  input wire kgsr_pkg::value_t m_axis_tdata_o,
  input wire logic             m_axis_tlast_o
);

  // stalled output item holds
  `KGSR_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))

  // end of list always closes a group and blocks input while it drains
  `KGSR_ASSERT(a_last_blocks, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |=> !s_axis_tready_o)

  // a new output item only comes out of a draining group
  `KGSR_ASSERT(a_out_from_drain, clk_i, rst_ni, $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o))

  // nothing shown on the output while in reset
  `KGSR_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !m_axis_tvalid_o)

endmodule

bind k_group_stream_reverser kgsr_checker u_kgsr_checker (.*);

`default_nettype wire
